@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled while reset is high
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication check
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ src/fvc_pkg.sv @@
package fvc_pkg;
  localparam int FLOW_FRAC_BITS_DEF = 8;
  localparam int FLOW_WIDTH_DEF = 16;
  localparam logic [7:0] GAIN_RESET = 8'd10;
  localparam int TAN_N = 22;
  localparam int HUE_ZERO_VEC = 90;

  // tan(2m deg) in q16, m = 1..22
  function automatic logic [15:0] tan_q16(input logic [4:0] m);
    logic [15:0] t;
    case (m)
      5'd1: t = 16'd2289;   5'd2: t = 16'd4583;   5'd3: t = 16'd6888;
      5'd4: t = 16'd9210;   5'd5: t = 16'd11556;  5'd6: t = 16'd13930;
      5'd7: t = 16'd16340;  5'd8: t = 16'd18792;  5'd9: t = 16'd21294;
      5'd10: t = 16'd23853; 5'd11: t = 16'd26478; 5'd12: t = 16'd29179;
      5'd13: t = 16'd31964; 5'd14: t = 16'd34846; 5'd15: t = 16'd37837;
      5'd16: t = 16'd40951; 5'd17: t = 16'd44205; 5'd18: t = 16'd47615;
      5'd19: t = 16'd51202; 5'd20: t = 16'd54991; 5'd21: t = 16'd59009;
      5'd22: t = 16'd63287;
      default: t = 16'd0;
    endcase
    return t;
  endfunction
endpackage

@@ src/fvc_hue.sv @@
module fvc_hue
  import fvc_pkg::*;
#(
  parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [FLOW_WIDTH-1:0] flow_x,
  input  logic signed [FLOW_WIDTH-1:0] flow_y,
  output logic [7:0]                   hue
);
  localparam int AW = FLOW_WIDTH + 1;
  localparam int PW = AW + 16;

  logic [AW-1:0] a_in, b_in;
  logic [1:0]    q_in;
  logic          z_in, sw_in;
  logic signed [AW-1:0] u, v;

  // quadrant of (-x, -y) and fold into first octant
  always_comb begin
    u = -{flow_x[FLOW_WIDTH-1], flow_x};
    v = -{flow_y[FLOW_WIDTH-1], flow_y};
    z_in = (u == '0) && (v == '0);
    if (u > 0 && v >= 0) begin
      q_in = 2'd0; a_in = AW'(u); b_in = AW'(v);
    end else if (u <= 0 && v > 0) begin
      q_in = 2'd1; a_in = AW'(v); b_in = AW'(-u);
    end else if (u < 0 && v <= 0) begin
      q_in = 2'd2; a_in = AW'(-u); b_in = AW'(-v);
    end else begin
      q_in = 2'd3; a_in = AW'(-v); b_in = AW'(u);
    end
    sw_in = b_in > a_in;
  end

  // stage 1: ordered operands
  logic [AW-1:0] lo1, hi1;
  logic [1:0]    q1;
  logic          z1, sw1;
  always_ff @(posedge clk) begin
    if (en) begin
      lo1 <= sw_in ? a_in : b_in;
      hi1 <= sw_in ? b_in : a_in;
      q1  <= q_in;
      z1  <= z_in;
      sw1 <= sw_in;
    end
  end

  // stage 2: parallel threshold compares against the tangent table
  logic [TAN_N-1:0] ge1;
  always_comb begin
    for (int m = 1; m <= TAN_N; m++) begin
      if (sw1)
        ge1[m-1] = ({16'd0, hi1} * PW'(tan_q16(5'(m)))) >= {lo1, 16'd0};
      else
        ge1[m-1] = {lo1, 16'd0} >= ({16'd0, hi1} * PW'(tan_q16(5'(m))));
    end
  end
  logic [TAN_N-1:0] ge2;
  logic [1:0]       q2;
  logic             z2, sw2;
  always_ff @(posedge clk) begin
    if (en) begin
      ge2 <= ge1; q2 <= q1; z2 <= z1; sw2 <= sw1;
    end
  end

  // stage 3: count and assemble hue
  logic [4:0] cnt;
  always_comb begin
    cnt = '0;
    for (int m = 0; m < TAN_N; m++) cnt = cnt + 5'(ge2[m]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (z2) hue <= 8'(HUE_ZERO_VEC);
      else hue <= 8'(q2) * 8'd45 + (sw2 ? 8'd22 : 8'd0) + 8'(cnt);
    end
  end
endmodule

@@ src/fvc_value.sv @@
module fvc_value
  import fvc_pkg::*;
#(
  parameter int FLOW_WIDTH     = FLOW_WIDTH_DEF,
  parameter int FLOW_FRAC_BITS = FLOW_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [FLOW_WIDTH-1:0] flow_x,
  input  logic signed [FLOW_WIDTH-1:0] flow_y,
  input  logic [7:0]                   gain,
  output logic [7:0]                   val
);
  localparam int MW = FLOW_WIDTH;
  localparam int CW = 2 * MW + 2 * FLOW_FRAC_BITS + 20;

  // stage 1: magnitudes times gain
  logic [MW-1:0] ax, ay;
  assign ax = flow_x[MW-1] ? MW'(-flow_x) : MW'(flow_x);
  assign ay = flow_y[MW-1] ? MW'(-flow_y) : MW'(flow_y);
  logic [MW+7:0] gx, gy;
  always_ff @(posedge clk) begin
    if (en) begin
      gx <= (MW+8)'(ax) * (MW+8)'(gain);
      gy <= (MW+8)'(ay) * (MW+8)'(gain);
    end
  end

  // stage 2: squares
  logic [2*MW+15:0] sx, sy;
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= (2*MW+16)'(gx) * (2*MW+16)'(gx);
      sy <= (2*MW+16)'(gy) * (2*MW+16)'(gy);
    end
  end

  // stage 3: sum of squares
  logic [2*MW+16:0] s;
  always_ff @(posedge clk) begin
    if (en) s <= {1'b0, sx} + {1'b0, sy};
  end

  // stage 4: rounded root by threshold search, 255 compares in parallel
  // thresholds are ((2k-1)*2^(F-1))^2, k from 1 to 255
  logic [255:0] hit;
  always_comb begin
    logic [CW-1:0] thr;
    hit = '0;
    for (int k = 1; k < 256; k++) begin
      thr = CW'((2 * k - 1) << (FLOW_FRAC_BITS - 1));
      hit[k] = CW'(s) >= thr * thr;
    end
  end
  logic [7:0] kcnt;
  always_comb begin
    kcnt = '0;
    for (int k = 1; k < 256; k++) if (hit[k]) kcnt = 8'(k);
  end
  always_ff @(posedge clk) begin
    if (en) val <= kcnt;
  end
endmodule

@@ src/flow_vector_to_color_top.sv @@
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------
// in       | flow_x, flow_y                 | start, busy (always low)
// out      | blue, green, red               | done strobe, one cycle
// config   | value_gain_we, value_gain      | write enable
//
// one item per cycle; start runs down the valid bits to done alongside the data
// the value path (gain multiply, square, sum, root search, color) sets depth
// hue path is padded to match; the output cannot be stalled
// rst synchronously clears valid bits and sets gain to 10
module flow_vector_to_color_top
  import fvc_pkg::*;
#(
  parameter int FLOW_WIDTH     = FLOW_WIDTH_DEF,
  parameter int FLOW_FRAC_BITS = FLOW_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [FLOW_WIDTH-1:0] flow_x,
  input  logic signed [FLOW_WIDTH-1:0] flow_y,
  input  logic                         value_gain_we,
  input  logic [7:0]                   value_gain,
  output logic                         done,
  output logic [7:0]                   blue,
  output logic [7:0]                   green,
  output logic [7:0]                   red
);
`include "assert_macros.svh"

  logic [7:0] gain;
  always_ff @(posedge clk) begin
    if (rst) gain <= GAIN_RESET;
    else if (value_gain_we) gain <= value_gain;
  end

  assign busy = 1'b0;

  // valid bits down the pipe
  logic [5:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[4:0], start};
  end

  logic [7:0] hue3, val4;
  fvc_hue #(.FLOW_WIDTH(FLOW_WIDTH)) u_hue (
    .clk(clk), .en(1'b1), .flow_x(flow_x), .flow_y(flow_y), .hue(hue3)
  );
  fvc_value #(.FLOW_WIDTH(FLOW_WIDTH), .FLOW_FRAC_BITS(FLOW_FRAC_BITS)) u_val (
    .clk(clk), .en(1'b1), .flow_x(flow_x), .flow_y(flow_y), .gain(gain),
    .val(val4)
  );

  // hue delay to line up; then sector split
  logic [7:0] hue4;
  always_ff @(posedge clk) hue4 <= hue3;
  logic [2:0] sec;
  logic [4:0] fr;
  always_comb begin
    if (hue4 >= 8'd150) sec = 3'd5;
    else if (hue4 >= 8'd120) sec = 3'd4;
    else if (hue4 >= 8'd90) sec = 3'd3;
    else if (hue4 >= 8'd60) sec = 3'd2;
    else if (hue4 >= 8'd30) sec = 3'd1;
    else sec = 3'd0;
    fr  = 5'(hue4 - 8'(sec) * 8'd30);
  end

  // stage 5: products
  logic [12:0] prise, pfall;
  logic [7:0]  v5;
  logic [2:0]  sec5;
  always_ff @(posedge clk) begin
    prise <= 13'(val4) * 13'(fr) + 13'd15;
    pfall <= 13'(val4) * 13'(5'd30 - fr) + 13'd15;
    v5 <= val4;
    sec5 <= sec;
  end

  // stage 6: divide by 30 via reciprocal and channel select
  logic [7:0] rise, fall;
  assign rise = 8'((30'(prise) * 30'd34953) >> 20);
  assign fall = 8'((30'(pfall) * 30'd34953) >> 20);
  always_ff @(posedge clk) begin
    case (sec5)
      3'd0: begin blue <= 8'd0; green <= rise; red <= v5; end
      3'd1: begin blue <= 8'd0; green <= v5; red <= fall; end
      3'd2: begin blue <= rise; green <= v5; red <= 8'd0; end
      3'd3: begin blue <= v5; green <= fall; red <= 8'd0; end
      3'd4: begin blue <= v5; green <= 8'd0; red <= rise; end
      default: begin blue <= fall; green <= 8'd0; red <= v5; end
    endcase
  end
  assign done = vld[5];

  `CHK_NEXT(a_lat, clk, rst, start, vld[0])
  `CHK_IMPL(a_zero, clk, rst, done && $past(gain == 8'd0, 6) && $past(!value_gain_we, 5),
            blue == 8'd0 && green == 8'd0 && red == 8'd0)
  `CHK_IMPL(a_busy, clk, rst, 1'b1, !busy)
endmodule

@@ test/flow_vector_to_color_top_test.sv @@
`timescale 1ns / 1ps

module flow_vector_to_color_top_test;
  import fvc_pkg::*;

  localparam int FW = FLOW_WIDTH_DEF;
  localparam int FB = FLOW_FRAC_BITS_DEF;
  localparam int LATENCY = 6;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } color_t;

  typedef struct {
    logic signed [FW-1:0] fx;
    logic signed [FW-1:0] fy;
    bit                   known;
    color_t               color;
  } vec_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [FW-1:0] flow_x = '0;
  logic signed [FW-1:0] flow_y = '0;
  logic                 value_gain_we = 1'b0;
  logic [7:0]           value_gain = GAIN_RESET;
  logic                 done;
  logic [7:0]           blue, green, red;

  flow_vector_to_color_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .flow_x(flow_x), .flow_y(flow_y),
    .value_gain_we(value_gain_we), .value_gain(value_gain),
    .done(done), .blue(blue), .green(green), .red(red)
  );

  always #4 clk = ~clk;

  // model copy of the gain register
  logic [7:0] gain_shadow;
  color_t     pixel_queue[$];
  int         mismatch_count = 0;
  int         pixel_count = 0;
  int         sent_count = 0;
  bit         quiet_stretch = 1'b0;

  // tangent table, 2-degree steps
  function automatic longint tan2deg(input int m);
    case (m)
      1: return 2289;   2: return 4583;   3: return 6888;   4: return 9210;
      5: return 11556;  6: return 13930;  7: return 16340;  8: return 18792;
      9: return 21294;  10: return 23853; 11: return 26478; 12: return 29179;
      13: return 31964; 14: return 34846; 15: return 37837; 16: return 40951;
      17: return 44205; 18: return 47615; 19: return 51202; 20: return 54991;
      21: return 59009; 22: return 63287;
      default: return 0;
    endcase
  endfunction

  // hue from direction of the reversed vector
  function automatic int flow_hue(input longint fx, input longint fy);
    longint u, v, a, b;
    int q, c;
    u = -fx;
    v = -fy;
    c = 0;
    if (u == 0 && v == 0) return HUE_ZERO_VEC;
    if (u > 0 && v >= 0) begin
      q = 0; a = u; b = v;
    end else if (u <= 0 && v > 0) begin
      q = 1; a = v; b = -u;
    end else if (u < 0 && v <= 0) begin
      q = 2; a = -u; b = -v;
    end else begin
      q = 3; a = -v; b = u;
    end
    if (b <= a) begin
      for (int m = 1; m <= TAN_N; m++)
        if (b * 65536 >= a * tan2deg(m)) c++;
    end else begin
      c = TAN_N;
      for (int m = 1; m <= TAN_N; m++)
        if (a * 65536 <= b * tan2deg(m)) c++;
    end
    return 45 * q + c;
  endfunction

  // rounded, saturated brightness from magnitude times gain
  function automatic int flow_value(input longint fx, input longint fy, input int g);
    longint s, t;
    int k, cand;
    s = (fx * fx + fy * fy) * longint'(g * g);
    k = 0;
    for (int bt = 128; bt != 0; bt = bt >> 1) begin
      cand = k | bt;
      t = longint'(2 * cand - 1) << (FB - 1);
      if (s >= t * t) k = cand;
    end
    return k;
  endfunction

  function automatic color_t flow_color(input logic signed [FW-1:0] fx,
                                        input logic signed [FW-1:0] fy,
                                        input logic [7:0] g);
    int h, val, fr, rise, fall;
    color_t c;
    h = flow_hue(fx, fy);
    val = flow_value(fx, fy, g);
    fr = h % 30;
    rise = (val * fr + 15) / 30;
    fall = (val * (30 - fr) + 15) / 30;
    case (h / 30)
      0: c = '{8'd0, rise[7:0], val[7:0]};
      1: c = '{8'd0, val[7:0], fall[7:0]};
      2: c = '{rise[7:0], val[7:0], 8'd0};
      3: c = '{val[7:0], fall[7:0], 8'd0};
      4: c = '{val[7:0], 8'd0, rise[7:0]};
      default: c = '{fall[7:0], 8'd0, val[7:0]};
    endcase
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      pixel_count++;
      if (pixel_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected pixel b=%0d g=%0d r=%0d", blue, green, red);
      end else begin
        color_t e;
        e = pixel_queue.pop_front();
        if (e.b !== blue || e.g !== green || e.r !== red) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     e.b, e.g, e.r, blue, green, red);
        end
      end
    end
  end

  // present one vector and wait for acceptance
  task automatic send_vector(input logic signed [FW-1:0] fx,
                             input logic signed [FW-1:0] fy);
    start <= 1'b1;
    flow_x <= fx;
    flow_y <= fy;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_queue.push_back(flow_color(fx, fy, gain_shadow));
    sent_count++;
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 35) begin
        start <= 1'b0;
        flow_x <= FW'($urandom);
        flow_y <= FW'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_gain(input logic [7:0] g);
    value_gain_we <= 1'b1;
    value_gain <= g;
    @(posedge clk);
    value_gain_we <= 1'b0;
    gain_shadow = g;
  endtask

  // random vector: mostly small motion, some full range
  task automatic send_random();
    logic signed [FW-1:0] fx, fy;
    case ($urandom_range(3))
      0: begin
        fx = FW'($urandom);
        fy = FW'($urandom);
      end
      1: begin
        fx = FW'($signed($urandom_range(0, 8191)) - 4096);
        fy = FW'($signed($urandom_range(0, 8191)) - 4096);
      end
      2: begin
        fx = FW'($signed($urandom_range(0, 1023)) - 512);
        fy = FW'($signed($urandom_range(0, 1023)) - 512);
      end
      default: begin
        fx = FW'($signed($urandom_range(0, 63)) - 32);
        fy = ($urandom_range(1)) ? '0 : FW'($urandom);
      end
    endcase
    send_vector(fx, fy);
  endtask

  vec_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{16'sh8000, 16'sd0, 1'b1, '{8'd0, 8'd0, 8'd255}},
    '{16'sd256, 16'sd0, 1'b0, '0},
    '{-16'sd256, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd256, 1'b0, '0},
    '{16'sd0, -16'sd256, 1'b0, '0},
    '{16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh7fff, 16'sh8000, 1'b0, '0},
    '{16'sh8000, 16'sh7fff, 1'b0, '0},
    '{16'sd1, 16'sd0, 1'b0, '0},
    '{-16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd1, 1'b0, '0},
    '{-16'sd1, -16'sd1, 1'b0, '0},
    '{16'sd300, -16'sd100, 1'b0, '0},
    '{-16'sd77, 16'sd500, 1'b0, '0},
    '{16'sd1000, 16'sd999, 1'b0, '0},
    '{16'sd13, 16'sd0, 1'b0, '0},
    '{16'sd12, 16'sd0, 1'b0, '0},
    '{-16'sd5000, -16'sd60, 1'b0, '0}
  };

  logic [7:0] gain_plan[] = '{8'd0, 8'd255, 8'd1, 8'd37, 8'd128};

  initial begin
    gain_shadow = GAIN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed vectors at reset gain
    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i].fx, directed_rows[i].fy);
      if (directed_rows[i].known) begin
        pixel_queue.pop_back();
        pixel_queue.push_back(directed_rows[i].color);
      end
    end
    drain_pixels();

    // several gain settings, each with random vectors
    foreach (gain_plan[p]) begin
      write_gain(gain_plan[p]);
      if (p == 1) begin
        foreach (directed_rows[i]) send_vector(directed_rows[i].fx, directed_rows[i].fy);
      end
      quiet_stretch = (p == 2);
      for (int n = 0; n < 320; n++) begin
        send_random();
        // pause until everything is out
        if (n == 150) drain_pixels();
      end
      quiet_stretch = 1'b0;
      drain_pixels();
    end

    $display("sent %0d flow vectors over %0d gain settings, checked %0d pixels",
             sent_count, gain_plan.size() + 1, pixel_count);
    if (mismatch_count == 0 && pixel_queue.size() == 0)
      $display("flow_vector_to_color_top_test passed");
    else
      $display("flow_vector_to_color_top_test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("flow_vector_to_color_top_test failed");
    $finish;
  end

endmodule
